FILE: rtl/core/alpha_over_blend_top_defines.svh
// Assertion macros for the alpha-over blend RTL.
`ifndef ALPHA_OVER_BLEND_TOP_DEFINES_SVH
`define ALPHA_OVER_BLEND_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define AOB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define AOB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AOB_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define AOB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/aob_pkg.sv
// Types and constants shared by the alpha-over blend modules.
package aob_pkg;

    localparam int CHAN_W = 8;
    localparam int DEN_W  = 2 * CHAN_W;
    localparam int NUM_W  = 3 * CHAN_W;
    localparam int Q_W    = CHAN_W;
    localparam int LANES  = 4;
    localparam int COLORS = 3;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    localparam int LANE_R = 0;
    localparam int LANE_G = 1;
    localparam int LANE_B = 2;
    localparam int LANE_A = 3;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_rgba;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   quot;
    } t_div_lane;

    typedef t_div_lane [LANES-1:0] t_div_word;

endpackage

FILE: rtl/core/aob_front.sv
// Weight and numerator stages ahead of the divider chain.
module aob_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  aob_pkg::t_rgba    i_src,
    input  aob_pkg::t_rgba    i_dst,
    output logic              o_valid,
    input  logic              i_ready,
    output aob_pkg::t_div_word o_div
);
    import aob_pkg::*;

    logic                          r_v1;
    logic                          r_v2;
    logic [DEN_W-1:0]              r_ws;
    logic [DEN_W-1:0]              r_wd;
    logic [DEN_W-1:0]              r_den;
    logic [COLORS-1:0][CHAN_W-1:0] r_cs;
    logic [COLORS-1:0][CHAN_W-1:0] r_cd;
    t_div_word                     r_div;

    logic [DEN_W-1:0]              n_ws;
    logic [DEN_W-1:0]              n_wd;
    logic [DEN_W-1:0]              n_den;
    t_div_word                     n_div;
    logic                          w_rdy1;
    logic                          w_rdy2;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_div   = r_div;

    always_comb begin
        n_ws  = {i_src.alpha, {CHAN_W{1'b0}}} - DEN_W'(i_src.alpha);
        n_wd  = DEN_W'(CHAN_MAX - i_src.alpha) * DEN_W'(i_dst.alpha);
        n_den = n_ws + n_wd;
    end

    always_comb begin
        for (int l = 0; l < COLORS; l++) begin
            n_div[l].rem  = NUM_W'(r_cs[l]) * NUM_W'(r_ws) + NUM_W'(r_cd[l]) * NUM_W'(r_wd);
            n_div[l].den  = (r_den == '0) ? DEN_W'(1) : r_den;
            n_div[l].quot = '0;
        end
        n_div[LANE_A].rem  = NUM_W'(r_den);
        n_div[LANE_A].den  = DEN_W'(CHAN_MAX);
        n_div[LANE_A].quot = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy1) begin
            r_ws  <= n_ws;
            r_wd  <= n_wd;
            r_den <= n_den;
            r_cs  <= {i_src.blue, i_src.green, i_src.red};
            r_cd  <= {i_dst.blue, i_dst.green, i_dst.red};
        end
        if (r_v1 && w_rdy2) begin
            r_div <= n_div;
        end
    end

endmodule

FILE: rtl/core/aob_div_cell.sv
// One restoring-division cell: resolves one quotient bit on every lane.
module aob_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  aob_pkg::t_div_word i_div,
    output logic               o_valid,
    input  logic               i_ready,
    output aob_pkg::t_div_word o_div
);
    import aob_pkg::*;

    logic      r_valid;
    t_div_word r_div;
    t_div_word n_div;
    logic      w_rdy;

    assign w_rdy   = !r_valid || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_valid;
    assign o_div   = r_div;

    always_comb begin
        logic [NUM_W-1:0] w_sub;
        logic [NUM_W:0]   w_trial;
        n_div = i_div;
        for (int l = 0; l < LANES; l++) begin
            w_sub   = NUM_W'(i_div[l].den) << SHIFT;
            w_trial = {1'b0, i_div[l].rem} - {1'b0, w_sub};
            if (!w_trial[NUM_W]) begin
                n_div[l].rem         = w_trial[NUM_W-1:0];
                n_div[l].quot[SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy) begin
            r_div <= n_div;
        end
    end

endmodule

FILE: rtl/core/alpha_over_blend_top.sv
// Top level of the alpha-over blend: straight-alpha RGBA source-over-destination.
//
// Input channel: i_in_valid / o_in_ready carry one source and one destination
// pixel, 8-bit straight RGBA each. Output channel: o_out_valid / i_out_ready
// carry the composite pixel. A transaction moves on a clock edge with valid
// and ready both high.
// Two stages form the alpha weights and the per-channel numerators, then a chain
// of 8 divider cells resolves one quotient bit each, on all four channels side by
// side. Throughput is one pixel per cycle while the receiver does not stall;
// every cell is a register stage of its own.
// The last cell's register is the output register.
// Both alphas zero gives an all-zero pixel.
// Reset empties every stage; nothing in flight survives it.
// When the receiver stalls, the result holds at the outputs and the stages
// behind it keep filling their empty slots, so input is still taken until
// the whole chain is full.
`include "alpha_over_blend_top_defines.svh"
module alpha_over_blend_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_src_red,
    input  logic [7:0] i_src_green,
    input  logic [7:0] i_src_blue,
    input  logic [7:0] i_src_alpha,
    input  logic [7:0] i_dst_red,
    input  logic [7:0] i_dst_green,
    input  logic [7:0] i_dst_blue,
    input  logic [7:0] i_dst_alpha,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha
);
    import aob_pkg::*;

    t_rgba               w_src;
    t_rgba               w_dst;
    t_div_word [Q_W:0]   w_div;
    logic      [Q_W:0]   w_vld;
    logic      [Q_W:0]   w_rdy;

    assign w_src = '{red: i_src_red, green: i_src_green, blue: i_src_blue, alpha: i_src_alpha};
    assign w_dst = '{red: i_dst_red, green: i_dst_green, blue: i_dst_blue, alpha: i_dst_alpha};

    aob_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_src   (w_src),
        .i_dst   (w_dst),
        .o_valid (w_vld[0]),
        .i_ready (w_rdy[0]),
        .o_div   (w_div[0])
    );

    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        aob_div_cell #(
            .SHIFT (Q_W - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[k]),
            .o_ready (w_rdy[k]),
            .i_div   (w_div[k]),
            .o_valid (w_vld[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_div   (w_div[k+1])
        );
    end

    assign w_rdy[Q_W]  = i_out_ready;
    assign o_out_valid = w_vld[Q_W];
    assign o_out_red   = w_div[Q_W][LANE_R].quot;
    assign o_out_green = w_div[Q_W][LANE_G].quot;
    assign o_out_blue  = w_div[Q_W][LANE_B].quot;
    assign o_out_alpha = w_div[Q_W][LANE_A].quot;

    `AOB_ASSERT_IMPL(a_rem_below_den, i_clk, i_rst_n, o_out_valid, (w_div[Q_W][LANE_R].rem < NUM_W'(w_div[Q_W][LANE_R].den)) && (w_div[Q_W][LANE_A].rem < NUM_W'(w_div[Q_W][LANE_A].den)))
    `AOB_ASSERT_IMPL(a_den_nonzero, i_clk, i_rst_n, w_vld[0], (w_div[0][LANE_G].den != '0) && (w_div[0][LANE_A].den == DEN_W'(CHAN_MAX)))
    `AOB_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n, o_out_valid && i_out_ready && !w_vld[Q_W-1], !o_out_valid)

endmodule

FILE: bench/testbench.sv
// Testbench for alpha_over_blend_top: source-over-destination composite with handshake checks.
`timescale 1ns / 1ps
module testbench;
    import aob_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_src_red;
    logic [7:0] i_src_green;
    logic [7:0] i_src_blue;
    logic [7:0] i_src_alpha;
    logic [7:0] i_dst_red;
    logic [7:0] i_dst_green;
    logic [7:0] i_dst_blue;
    logic [7:0] i_dst_alpha;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_red;
    logic [7:0] o_out_green;
    logic [7:0] o_out_blue;
    logic [7:0] o_out_alpha;

    t_rgba composite_q[$];
    int    error_count = 0;
    bit    src_gaps = 1'b0;
    bit    sink_stalls = 1'b0;
    int    sink_hold_cycles = 0;

    alpha_over_blend_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_src_red   (i_src_red),
        .i_src_green (i_src_green),
        .i_src_blue  (i_src_blue),
        .i_src_alpha (i_src_alpha),
        .i_dst_red   (i_dst_red),
        .i_dst_green (i_dst_green),
        .i_dst_blue  (i_dst_blue),
        .i_dst_alpha (i_dst_alpha),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] mix_channel(input logic [7:0] cs, input logic [7:0] cd,
                                               input logic [31:0] ws, input logic [31:0] wd,
                                               input logic [31:0] den);
        logic [31:0] num;
        if (den == 32'd0) begin
            return 8'd0;
        end
        num = 32'(cs) * ws + 32'(cd) * wd;
        return 8'(num / den);
    endfunction

    function automatic t_rgba blend_over(input t_rgba src, input t_rgba dst);
        logic [31:0] w_src;
        logic [31:0] w_dst;
        logic [31:0] den;
        t_rgba       res;
        w_src     = 32'(src.alpha) * 32'(CHAN_MAX);
        w_dst     = (32'(CHAN_MAX) - 32'(src.alpha)) * 32'(dst.alpha);
        den       = w_src + w_dst;
        res.red   = mix_channel(src.red, dst.red, w_src, w_dst, den);
        res.green = mix_channel(src.green, dst.green, w_src, w_dst, den);
        res.blue  = mix_channel(src.blue, dst.blue, w_src, w_dst, den);
        res.alpha = 8'(den / 32'(CHAN_MAX));
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    // Offer one pixel pair; return at the edge that accepts it.
    task automatic send_pixel(input t_rgba src, input t_rgba dst);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_src_red   <= src.red;
        i_src_green <= src.green;
        i_src_blue  <= src.blue;
        i_src_alpha <= src.alpha;
        i_dst_red   <= dst.red;
        i_dst_green <= dst.green;
        i_dst_blue  <= dst.blue;
        i_dst_alpha <= dst.alpha;
        do @(posedge i_clk); while (!o_in_ready);
        composite_q.push_back(blend_over(src, dst));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (composite_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_alpha();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd254;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_color();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_rgba rand_pixel();
        t_rgba px;
        px.red   = rand_color();
        px.green = rand_color();
        px.blue  = rand_color();
        px.alpha = rand_alpha();
        return px;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_pixel(rand_pixel(), rand_pixel());
    endtask

    task automatic test_directed_corners();
        send_pixel('{8'd200, 8'd100, 8'd50, 8'd0},    '{8'd10, 8'd20, 8'd30, 8'd0});
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd0},   '{8'd255, 8'd255, 8'd255, 8'd0});
        send_pixel('{8'd12, 8'd34, 8'd56, 8'd255},    '{8'd200, 8'd150, 8'd100, 8'd255});
        send_pixel('{8'd12, 8'd34, 8'd56, 8'd0},      '{8'd200, 8'd150, 8'd100, 8'd255});
        send_pixel('{8'd255, 8'd0, 8'd255, 8'd255},   '{8'd0, 8'd255, 8'd0, 8'd0});
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd0},         '{8'd0, 8'd0, 8'd0, 8'd255});
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd255},       '{8'd0, 8'd0, 8'd0, 8'd255});
        send_pixel('{8'd255, 8'd128, 8'd1, 8'd1},     '{8'd0, 8'd127, 8'd254, 8'd1});
        send_pixel('{8'd255, 8'd0, 8'd170, 8'd254},   '{8'd0, 8'd255, 8'd85, 8'd255});
        send_pixel('{8'd255, 8'd0, 8'd255, 8'd128},   '{8'd0, 8'd255, 8'd0, 8'd128});
        send_pixel('{8'd170, 8'd85, 8'd170, 8'd85},   '{8'd85, 8'd170, 8'd85, 8'd170});
        send_pixel('{8'd85, 8'd170, 8'd85, 8'd170},   '{8'd170, 8'd85, 8'd170, 8'd85});
        send_pixel('{8'd1, 8'd254, 8'd128, 8'd255},   '{8'd254, 8'd1, 8'd127, 8'd0});
        send_pixel('{8'd99, 8'd99, 8'd99, 8'd1},      '{8'd255, 8'd255, 8'd255, 8'd0});
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd127}, '{8'd0, 8'd0, 8'd0, 8'd255});
    endtask

    task automatic test_random_stream();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        send_random(430);
    endtask

    task automatic test_backpressure_fill();
        src_gaps         = 1'b0;
        sink_hold_cycles = 200;
        send_random(40);
    endtask

    task automatic test_drain_pause();
        src_gaps = 1'b1;
        wait_drained();
        send_random(30);
    endtask

    task automatic test_full_rate();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        send_random(100);
    endtask

    initial begin : out_ready_gen
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                sink_hold_cycles--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(1, 16) - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : result_check
        t_rgba want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (composite_q.size() == 0) begin
                    report_error("result transaction with no pixel pending");
                end else begin
                    want = composite_q.pop_front();
                    if (o_out_red !== want.red)
                        report_error($sformatf("red got %0d expected %0d",
                                               o_out_red, want.red));
                    if (o_out_green !== want.green)
                        report_error($sformatf("green got %0d expected %0d",
                                               o_out_green, want.green));
                    if (o_out_blue !== want.blue)
                        report_error($sformatf("blue got %0d expected %0d",
                                               o_out_blue, want.blue));
                    if (o_out_alpha !== want.alpha)
                        report_error($sformatf("alpha got %0d expected %0d",
                                               o_out_alpha, want.alpha));
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_src_red   <= 8'd0;
        i_src_green <= 8'd0;
        i_src_blue  <= 8'd0;
        i_src_alpha <= 8'd0;
        i_dst_red   <= 8'd0;
        i_dst_green <= 8'd0;
        i_dst_blue  <= 8'd0;
        i_dst_alpha <= 8'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_random_stream();
        test_backpressure_fill();
        test_drain_pause();
        test_full_rate();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
